[hdl/tst_pkg.sv]
// Shared constants and types for the temporal successor table.
`default_nettype none
package tst_pkg;
  localparam int unsigned NumSetsDef   = 512;
  localparam int unsigned NumWaysDef   = 4;
  localparam int unsigned SuccSlotsDef = 8;
  localparam logic [63:0] HashMult     = 64'h9E3779B97F4A7C15;
  localparam int unsigned SetShift     = 20;
  localparam int unsigned SigW         = 64;
  localparam int unsigned BlkW         = 58;
  localparam int unsigned CntW         = 32;
  localparam int unsigned StampW       = 64;
  localparam logic [CntW-1:0] CountMax = '1;
  localparam logic [3:0] TopKReset     = 4'd4;
  localparam logic [0:0] RegTopK       = 1'b0;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_HASH  = 7'b0000010,
    ST_RDTAG = 7'b0000100,
    ST_WAY   = 7'b0001000,
    ST_SLOT  = 7'b0010000,
    ST_RANK  = 7'b0100000,
    ST_WRITE = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

[hdl/tst_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module tst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/temporal_successor_table.sv]
// Top level of the temporal successor table.
// Each transfer on the input channel (a miss signature and the block that followed it) yields
// one result transfer. The set index is hashed while the item is accepted. The result is valid
// after the states ST_HASH (memory read), ST_RDTAG (capture of the set's row), ST_WAY (way
// match), ST_SLOT (slot match), ST_RANK (rank count) and ST_WRITE (write-back). The sequencer
// handles one item at a time, so a new item is accepted only once the sequencer is idle again,
// and only once the previous result has left or is leaving. NUM_SETS must be a power of two.
// After reset a clearing pass writes the NUM_SETS rows to zero, one row per cycle, before
// the first item is accepted. Rows are a set wide: all ways, and all successor slots of each way.
`default_nettype none
module temporal_successor_table
  import tst_pkg::*;
#(
  parameter int unsigned NUM_SETS   = NumSetsDef,
  parameter int unsigned NUM_WAYS   = NumWaysDef,
  parameter int unsigned SUCC_SLOTS = SuccSlotsDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [SigW-1:0]  in_signature,
  input  wire logic [BlkW-1:0]  in_block,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_key_hit,
  output logic                  out_recurring,
  output logic                  out_in_top_k,
  output logic [2:0]            out_outranked_by,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [2:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  localparam int unsigned SetAw = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WayW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned SlotW = (SUCC_SLOTS > 1) ? $clog2(SUCC_SLOTS) : 1;
  localparam int unsigned UsedW = $clog2(SUCC_SLOTS + 1);
  localparam int unsigned RankW = $clog2(SUCC_SLOTS + 1);
  localparam int unsigned WayRecW  = 1 + SigW + StampW + UsedW;
  localparam int unsigned SlotRecW = BlkW + CntW;
  localparam int unsigned RowW  = NUM_WAYS * (WayRecW + SUCC_SLOTS * SlotRecW);
  localparam int unsigned SlotsW = SUCC_SLOTS * SlotRecW;
  localparam int unsigned HashW = SetShift + SetAw;

  typedef struct packed {
    logic               valid;
    logic [SigW-1:0]    tag;
    logic [StampW-1:0]  stamp;
    logic [UsedW-1:0]   used;
  } way_rec_t;
  typedef struct packed {
    logic [BlkW-1:0] blk;
    logic [CntW-1:0] cnt;
  } slot_rec_t;

  // Configuration.
  logic [3:0] top_k_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_k_r <= TopKReset;
    end else if (cfg_wr && cfg_paddr[2] == RegTopK && cfg_paddr[1:0] == 2'b00) begin
      top_k_r <= cfg_pwdata[3:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == RegTopK) ? {28'd0, top_k_r} : 32'd0;

  // Memory: one row per set.
  logic             ram_we;
  logic [SetAw-1:0] ram_waddr;
  logic [RowW-1:0]  ram_wdata;
  logic [SetAw-1:0] ram_raddr;
  logic [RowW-1:0]  ram_rdata;
  tst_ram #(.Width(RowW), .Depth(NUM_SETS)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  state_t state_r;
  logic   clr_busy_r;
  logic [SetAw:0] clr_idx_r;
  logic [SigW-1:0]  sig_r;
  logic [BlkW-1:0]  blk_r;
  logic [SetAw-1:0] set_r;
  logic [RowW-1:0]  row_r;
  logic [StampW-1:0] clock_r;
  logic              hit_r;
  logic [WayW-1:0]   hway_r, vic_r;
  logic [SlotsW-1:0] slots_r;
  logic [UsedW-1:0]  used_r;
  logic              seen_r;
  logic [SlotW-1:0]  sidx_r;
  logic [CntW-1:0]   bc_r;
  logic [SlotW-1:0]  mn_r;
  logic [RankW-1:0]  better_r;
  logic              out_valid_r, o_hit_r, o_rec_r, o_top_r;
  logic [2:0]        o_outr_r;

  // Only the low HashW bits of the product reach the set field.
  logic [SetAw-1:0] set_c;
  assign set_c = SetAw'((in_signature[HashW-1:0] * HashMult[HashW-1:0]) >> SetShift);

  way_rec_t  ways [NUM_WAYS];
  slot_rec_t slots [SUCC_SLOTS];
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      ways[w] = row_r[w*WayRecW +: WayRecW];
    end
    for (int k = 0; k < SUCC_SLOTS; k++) begin
      slots[k] = slots_r[k*SlotRecW +: SlotRecW];
    end
  end

  // Way match and LRU victim.
  logic             hit_c;
  logic [WayW-1:0]  hway_c, vic_c;
  always_comb begin
    hit_c  = 1'b0;
    hway_c = '0;
    vic_c  = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (ways[w].valid && ways[w].tag == sig_r) begin
        hit_c  = 1'b1;
        hway_c = WayW'(w);
      end
      if (!ways[w].valid || ways[w].stamp < ways[vic_c].stamp) begin
        vic_c = WayW'(w);
      end
    end
  end

  // Slot match and first minimum.
  logic             seen_c;
  logic [SlotW-1:0] sidx_c, mn_c;
  logic [UsedW-1:0] used_c;
  always_comb begin
    used_c = (used_r > UsedW'(SUCC_SLOTS)) ? UsedW'(SUCC_SLOTS) : used_r;
    seen_c = 1'b0;
    sidx_c = '0;
    mn_c   = '0;
    for (int k = 0; k < SUCC_SLOTS; k++) begin
      if (UsedW'(k) < used_c && slots[k].blk == blk_r && !seen_c) begin
        seen_c = 1'b1;
        sidx_c = SlotW'(k);
      end
      if (slots[k].cnt < slots[mn_c].cnt) begin
        mn_c = SlotW'(k);
      end
    end
  end

  // Rank against the found count; slots with the same block match the found one.
  logic [RankW-1:0] better_c;
  always_comb begin
    better_c = '0;
    for (int k = 0; k < SUCC_SLOTS; k++) begin
      if (UsedW'(k) < used_r && slots[k].blk != blk_r && slots[k].cnt > bc_r) begin
        better_c = better_c + RankW'(1);
      end
    end
  end

  // Write-back row.
  logic [RowW-1:0]   row_nxt;
  logic [SlotsW-1:0] slots_nxt;
  way_rec_t          wr_way;
  slot_rec_t         new_slot;
  logic [StampW-1:0] clock_nxt;
  always_comb begin
    clock_nxt = clock_r + StampW'(1);
    new_slot  = '{blk: blk_r, cnt: CntW'(1)};
    slots_nxt = slots_r;
    if (hit_r) begin
      wr_way       = ways[hway_r];
      wr_way.stamp = clock_nxt;
      if (seen_r) begin
        if (slots[sidx_r].cnt != CountMax) begin
          slots_nxt[sidx_r*SlotRecW +: SlotRecW] =
            {slots[sidx_r].blk, slots[sidx_r].cnt + CntW'(1)};
        end
      end else if (used_r < UsedW'(SUCC_SLOTS)) begin
        slots_nxt[SlotW'(used_r)*SlotRecW +: SlotRecW] = new_slot;
        wr_way.used = used_r + UsedW'(1);
      end else if (slots[mn_r].cnt <= CntW'(1)) begin
        slots_nxt[mn_r*SlotRecW +: SlotRecW] = new_slot;
      end
    end else begin
      wr_way = '{valid: 1'b1, tag: sig_r, stamp: clock_nxt, used: UsedW'(1)};
      slots_nxt[0 +: SlotRecW] = new_slot;
    end
    row_nxt = row_r;
    row_nxt[(hit_r ? hway_r : vic_r)*WayRecW +: WayRecW] = wr_way;
    row_nxt[NUM_WAYS*WayRecW + (hit_r ? hway_r : vic_r)*SlotsW +: SlotsW] = slots_nxt;
  end

  logic in_acc, out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || clr_busy_r || !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    ram_raddr = set_r;
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = row_nxt;
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r[SetAw-1:0];
      ram_wdata = '0;
    end else if (state_r == ST_WRITE) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + (SetAw+1)'(1);
        if (clr_idx_r == (SetAw+1)'(NUM_SETS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      case (state_r)
        ST_IDLE:  if (in_acc) state_r <= ST_HASH;
        ST_HASH:  state_r <= ST_RDTAG;
        ST_RDTAG: state_r <= ST_WAY;
        ST_WAY:   state_r <= ST_SLOT;
        ST_SLOT:  state_r <= ST_RANK;
        ST_RANK:  state_r <= ST_WRITE;
        ST_WRITE: begin
          state_r     <= ST_IDLE;
          clock_r     <= clock_nxt;
          out_valid_r <= 1'b1;
        end
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers. The set's row is read during ST_HASH and captured in ST_RDTAG.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sig_r <= in_signature;
          blk_r <= in_block;
          set_r <= set_c;
        end
      end
      ST_RDTAG: row_r <= ram_rdata;
      ST_WAY: begin
        hit_r   <= hit_c;
        hway_r  <= hit_c ? hway_c : vic_c;
        vic_r   <= vic_c;
        slots_r <= row_r[NUM_WAYS*WayRecW + (hit_c ? hway_c : vic_c)*SlotsW +: SlotsW];
        used_r  <= ways[hit_c ? hway_c : vic_c].used;
      end
      ST_SLOT: begin
        used_r <= used_c;
        seen_r <= seen_c;
        sidx_r <= sidx_c;
        mn_r   <= mn_c;
        bc_r   <= slots[sidx_c].cnt;
      end
      ST_RANK:  better_r <= better_c;
      ST_WRITE: begin
        o_hit_r  <= hit_r;
        o_rec_r  <= hit_r && seen_r;
        o_top_r  <= hit_r && seen_r && ({{(32-RankW){1'b0}}, better_r} < {28'd0, top_k_r});
        o_outr_r <= !(hit_r && seen_r) ? 3'd0 :
                    (better_r > RankW'(7)) ? 3'd7 : better_r[2:0];
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_key_hit      = o_hit_r;
  assign out_recurring    = o_rec_r;
  assign out_in_top_k     = o_top_r;
  assign out_outranked_by = o_outr_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == ST_IDLE && !clr_busy_r) else $error("accept while busy");
  a_result_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE |=> out_valid_r) else $error("missing result");
  a_no_write_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> state_r == ST_IDLE) else $error("item during clear");
  a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!o_rec_r || o_hit_r) && (!o_top_r || o_rec_r))
    else $error("inconsistent result flags");
endmodule
`default_nettype wire
